// ===== hw/rtl/chfc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, constants and the arctangent table of the compass heading block.
package chfc_pkg;

  // Field widths.
  localparam int RAW_W   = 17;
  localparam int FIELD_W = 18;
  localparam int DECL_W  = 16;
  localparam int HEAD_W  = 16;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;

  // Rotation stages. The table holds at most TABLE_LEN entries.
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int STAGE_IDX_W   = $clog2(TABLE_LEN);

  // Fixed-point formats: vector scaled by 2^PRESCALE, angle in 1/256 of 0.01 degree.
  localparam int PRESCALE  = 16;
  localparam int ANG_FRAC  = 8;
  localparam int XY_W      = FIELD_W + PRESCALE + 3;
  localparam int Z_W       = 25;
  localparam int ATAN_W    = 21;
  localparam int FULL_TURN = 36000;

  localparam logic signed [Z_W-1:0] FULL_Z = Z_W'(FULL_TURN * (1 << ANG_FRAC));
  localparam logic signed [Z_W-1:0] HALF_Z = Z_W'((FULL_TURN / 2) * (1 << ANG_FRAC));

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 2'd2;

  localparam logic signed [DECL_W-1:0] DECL_RESET = 16'sd538;

  // Data carried along the rotation chain.
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic                      zero;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
  } cord_t;

  // round(atan(2^-i) in degrees * 100 * 256).
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [STAGE_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] t;
    unique case (idx)
      5'd0:    t = 21'd1152000;
      5'd1:    t = 21'd680065;
      5'd2:    t = 21'd359328;
      5'd3:    t = 21'd182400;
      5'd4:    t = 21'd91554;
      5'd5:    t = 21'd45822;
      5'd6:    t = 21'd22916;
      5'd7:    t = 21'd11459;
      5'd8:    t = 21'd5730;
      5'd9:    t = 21'd2865;
      5'd10:   t = 21'd1432;
      5'd11:   t = 21'd716;
      5'd12:   t = 21'd358;
      5'd13:   t = 21'd179;
      5'd14:   t = 21'd90;
      5'd15:   t = 21'd45;
      5'd16:   t = 21'd22;
      5'd17:   t = 21'd11;
      5'd18:   t = 21'd6;
      5'd19:   t = 21'd3;
      5'd20:   t = 21'd1;
      5'd21:   t = 21'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/chfc_in_if.sv =====
`timescale 1ns / 1ps
// Sample channel: valid/ready handshake carrying one raw horizontal field sample.
interface chfc_in_if import chfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

// ===== hw/rtl/chfc_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying headings and corrected field.
interface chfc_out_if import chfc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [HEAD_W-1:0]  heading_magnetic;
  logic        [HEAD_W-1:0]  heading_geo;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;

  modport source (output valid, output heading_magnetic, output heading_geo,
                  output field_x, output field_y, input ready);
  modport sink   (input valid, input heading_magnetic, input heading_geo,
                  input field_x, input field_y, output ready);
endinterface

// ===== hw/rtl/chfc_front.sv =====
`timescale 1ns / 1ps
// Front end: hard-iron correction and the half-plane pre-rotation of the vector.
module chfc_front import chfc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  chfc_in_if.sink                 sample,
  input  logic signed [RAW_W-1:0] offset_x,
  input  logic signed [RAW_W-1:0] offset_y,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output cord_t                   dn_data
);

  logic                      va;
  logic                      ra;
  logic signed [FIELD_W-1:0] fx;
  logic signed [FIELD_W-1:0] fy;
  logic                      rb;
  logic signed [XY_W-1:0]    px;
  logic signed [XY_W-1:0]    py;
  cord_t                     pre;

  assign ra           = !va || rb;
  assign rb           = !dn_valid || dn_ready;
  assign sample.ready = ra;

  // First stage: subtract the offsets; the 18-bit difference always fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= sample.valid;
    end
    if (ra && sample.valid) begin
      fx <= FIELD_W'(sample.raw_x) - FIELD_W'(offset_x);
      fy <= FIELD_W'(sample.raw_y) - FIELD_W'(offset_y);
    end
  end

  // Scale up and fold the left half-plane onto the right, starting the angle at 180 degrees.
  always_comb begin
    px       = XY_W'(fx) <<< PRESCALE;
    py       = XY_W'(fy) <<< PRESCALE;
    pre.zero = (fx == '0) && (fy == '0);
    pre.fx   = fx;
    pre.fy   = fy;
    if (fx < 0) begin
      pre.x = -px;
      pre.y = -py;
      pre.z = HALF_Z;
    end else begin
      pre.x = px;
      pre.y = py;
      pre.z = '0;
    end
  end

  // Second stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (rb) begin
      dn_valid <= va;
    end
    if (rb && va) begin
      dn_data <= pre;
    end
  end

endmodule

// ===== hw/rtl/chfc_cell.sv =====
`timescale 1ns / 1ps
// One vectoring rotation cell of the chain, with its own register and handshake.
module chfc_cell import chfc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [STAGE_IDX_W-1:0] stage,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  cord_t                  up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output cord_t                  dn_data
);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  t;
  logic                   y_pos;
  cord_t                  nxt;

  assign up_ready = !dn_valid || dn_ready;

  // Rotate towards the x axis; both updates use the old x and y.
  always_comb begin
    xs    = up_data.x >>> stage;
    ys    = up_data.y >>> stage;
    t     = signed'(Z_W'(atan_entry(stage)));
    y_pos = !up_data.y[XY_W-1] && (up_data.y != '0);
    nxt   = up_data;
    if (y_pos) begin
      nxt.x = up_data.x + ys;
      nxt.y = up_data.y - xs;
      nxt.z = up_data.z + t;
    end else begin
      nxt.x = up_data.x - ys;
      nxt.y = up_data.y + xs;
      nxt.z = up_data.z - t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule

// ===== hw/rtl/chfc_back.sv =====
`timescale 1ns / 1ps
// Back end: angle wrap, rounding to 0.01 degree, declination and the output register.
module chfc_back import chfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  cord_t                    up_data,
  input  logic signed [DECL_W-1:0] declination,
  chfc_out_if.source               result
);

  localparam logic [Z_W-1:0] ROUND_HALF = Z_W'(1 << (ANG_FRAC - 1));
  localparam int             HR_W       = Z_W - ANG_FRAC;

  logic                      v1;
  logic                      v2;
  logic                      r2;
  logic                      r3;
  logic [Z_W-2:0]            zp;
  logic                      zero1;
  logic signed [FIELD_W-1:0] fx1;
  logic signed [FIELD_W-1:0] fy1;
  logic [HEAD_W-1:0]         hm;
  logic signed [FIELD_W-1:0] fx2;
  logic signed [FIELD_W-1:0] fy2;
  logic signed [Z_W-1:0]     zw;
  logic [Z_W-1:0]            zr;
  logic [HR_W-1:0]           hr;
  logic [HR_W-1:0]           hw;
  logic signed [HEAD_W+1:0]  sum;
  logic signed [HEAD_W+1:0]  tw;

  assign up_ready     = !v1 || r2;
  assign r2           = !v2 || r3;
  assign r3           = !result.valid || result.ready;

  // Bring a negative angle into the positive turn.
  assign zw = (up_data.z < 0) ? up_data.z + FULL_Z : up_data.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (up_ready) begin
      v1 <= up_valid;
    end
    if (up_ready && up_valid) begin
      zp    <= zw[Z_W-2:0];
      zero1 <= up_data.zero;
      fx1   <= up_data.fx;
      fy1   <= up_data.fy;
    end
  end

  // Round to hundredths; a full turn reads as zero, and so does a zero vector.
  always_comb begin
    zr = {1'b0, zp} + ROUND_HALF;
    hr = zr[Z_W-1:ANG_FRAC];
    hw = (hr >= HR_W'(FULL_TURN)) ? hr - HR_W'(FULL_TURN) : hr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      hm  <= zero1 ? '0 : hw[HEAD_W-1:0];
      fx2 <= fx1;
      fy2 <= fy1;
    end
  end

  // Add the declination; the sum lies within one turn either side of the range.
  always_comb begin
    sum = signed'({2'b00, hm}) + (HEAD_W + 2)'(declination);
    priority if (sum < 0) begin
      tw = sum + (HEAD_W + 2)'(FULL_TURN);
    end else if (sum >= (HEAD_W + 2)'(FULL_TURN)) begin
      tw = sum - (HEAD_W + 2)'(FULL_TURN);
    end else begin
      tw = sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (r3) begin
      result.valid <= v2;
    end
    if (r3 && v2) begin
      result.heading_magnetic <= hm;
      result.heading_geo      <= tw[HEAD_W-1:0];
      result.field_x          <= fx2;
      result.field_y          <= fy2;
    end
  end

endmodule

// ===== hw/rtl/compass_heading_from_field.sv =====
`timescale 1ns / 1ps
// Top level of the compass heading block: configuration registers and the rotation chain.
//
// Each transfer on the sample channel carries one raw horizontal field sample
// (raw_x, raw_y in milligauss). The hard-iron offsets are subtracted, the
// heading atan2(y, x) is found by a chain of vectoring rotation cells, one cell
// per stage, and the declination is added. Each sample gives exactly one
// transfer on the result channel: magnetic heading, true heading (both in
// hundredths of a degree, 0 to 35999) and the corrected field components.
// A zero corrected vector gives a magnetic heading of zero.
// The pipeline has two front-end stages, one register per rotation cell and
// three back-end stages including the output register. One sample is taken
// every cycle while the receiver takes results; every stage has its own valid
// bit, so bubbles close up and a new sample is taken while a result waits.
// When the receiver stalls, the chain fills up and the sample ready falls only
// once every stage holds a sample.
// The configuration port writes offset_x, offset_y and declination by index; the user
// must write it only while the block is idle, which the block does not enforce. Reset
// clears all valid bits and sets the offsets to zero and the declination to 5.38 degrees.
module compass_heading_from_field import chfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  chfc_in_if.sink              sample,
  chfc_out_if.source           result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic signed [RAW_W-1:0]  offset_x;
  logic signed [RAW_W-1:0]  offset_y;
  logic signed [DECL_W-1:0] declination;

  logic  [NUM_STAGES:0] c_valid;
  logic  [NUM_STAGES:0] c_ready;
  cord_t                c_data [NUM_STAGES+1];

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= '0;
      offset_y    <= '0;
      declination <= DECL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X:    offset_x    <= cfg_data;
        REG_OFFSET_Y:    offset_y    <= cfg_data;
        REG_DECLINATION: declination <= cfg_data[DECL_W-1:0];
        default: ;
      endcase
    end
  end

  chfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_data  (c_data[0])
  );

  // Chain of rotation cells, stage g shifting by g.
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    chfc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (STAGE_IDX_W'(g)),
      .up_valid (c_valid[g]),
      .up_ready (c_ready[g]),
      .up_data  (c_data[g]),
      .dn_valid (c_valid[g+1]),
      .dn_ready (c_ready[g+1]),
      .dn_data  (c_data[g+1])
    );
  end

  chfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (c_valid[NUM_STAGES]),
    .up_ready    (c_ready[NUM_STAGES]),
    .up_data     (c_data[NUM_STAGES]),
    .declination (declination),
    .result      (result)
  );

  // The chain holds nothing back while the output register is empty.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("sample channel stalled with an empty output register");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

  // Headings stay inside one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.heading_magnetic < HEAD_W'(FULL_TURN)) &&
                     (result.heading_geo < HEAD_W'(FULL_TURN)))
    else $error("heading outside 0 to 35999");

  // A zero corrected vector reads as north.
  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.field_x == '0) && (result.field_y == '0)
      |-> (result.heading_magnetic == '0))
    else $error("zero vector gave a non-zero heading");

endmodule

// ===== verif/compass_heading_from_field_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the compass heading block: directed table, then random samples.
module compass_heading_from_field_test;
  import chfc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LATENCY = CORDIC_STAGES + 5;
  localparam int PHASES = 8;
  localparam int SAMPLES_PER_PHASE = 244;

  // One result transfer as the block should produce it.
  typedef struct packed {
    logic        [HEAD_W-1:0]  hm;
    logic        [HEAD_W-1:0]  ht;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
  } reading_t;

  // One row of the directed table: either a register write or a sample.
  typedef struct packed {
    bit                      is_reg;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_W-1:0]        data;
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    bit                      typed;
    reading_t                want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  chfc_in_if  sample_ch ();
  chfc_out_if result_ch ();

  compass_heading_from_field u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Local copy of the configuration registers.
  logic signed [RAW_W-1:0]  cal_off_x;
  logic signed [RAW_W-1:0]  cal_off_y;
  logic signed [DECL_W-1:0] cal_decl;

  reading_t pending_readings[$];
  int       mismatch_count = 0;
  bit       quiet_tail = 1'b0;

  // Arctangent step of each rotation, in 1/256 of a hundredth of a degree.
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 1152000;
      1:  return 680065;
      2:  return 359328;
      3:  return 182400;
      4:  return 91554;
      5:  return 45822;
      6:  return 22916;
      7:  return 11459;
      8:  return 5730;
      9:  return 2865;
      10: return 1432;
      11: return 716;
      12: return 358;
      13: return 179;
      14: return 90;
      15: return 45;
      16: return 22;
      17: return 11;
      18: return 6;
      19: return 3;
      20: return 1;
      21: return 1;
      default: return 0;
    endcase
  endfunction

  // Vectoring rotation of the corrected field, giving atan2(fy, fx) in 0..35999.
  function automatic logic [HEAD_W-1:0] cordic_heading(input longint fx, input longint fy);
    longint x, y, z, nx, ny, h;
    int i;
    if (fx == 0 && fy == 0) return '0;
    x = fx * (longint'(1) << PRESCALE);
    y = fy * (longint'(1) << PRESCALE);
    z = 0;
    // The left half plane is folded over and starts at 180 degrees.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(FULL_TURN / 2) * (longint'(1) << ANG_FRAC);
    end
    for (i = 0; i < NUM_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_step(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_step(i);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = z + longint'(FULL_TURN) * (longint'(1) << ANG_FRAC);
    h = (z + (longint'(1) << (ANG_FRAC - 1))) >>> ANG_FRAC;
    if (h >= FULL_TURN) h = h - FULL_TURN;
    return h[HEAD_W-1:0];
  endfunction

  // Full reading for one raw sample under the current calibration.
  function automatic reading_t compute_reading(input logic signed [RAW_W-1:0] x,
                                               input logic signed [RAW_W-1:0] y);
    reading_t r;
    longint fx, fy, t;
    fx = longint'(x) - longint'(cal_off_x);
    fy = longint'(y) - longint'(cal_off_y);
    r.hm = cordic_heading(fx, fy);
    // The sum is reduced modulo a full turn, so large declinations wrap correctly.
    t = (longint'(r.hm) + longint'(cal_decl)) % FULL_TURN;
    if (t < 0) t = t + FULL_TURN;
    r.ht = t[HEAD_W-1:0];
    r.fx = fx[FIELD_W-1:0];
    r.fy = fy[FIELD_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t row_sample(input int x, input int y);
    dir_row_t r;
    r = '0;
    r.x = x[RAW_W-1:0];
    r.y = y[RAW_W-1:0];
    return r;
  endfunction

  // A sample that lands exactly on the offsets, so the expected reading is known outright.
  function automatic dir_row_t row_zero(input int x, input int y, input int ht);
    dir_row_t r;
    r = row_sample(x, y);
    r.typed = 1'b1;
    r.want.ht = ht[HEAD_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t row_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    dir_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data[CFG_W-1:0];
    return r;
  endfunction

  // Present one sample, wait for its transfer, then possibly leave a gap.
  task automatic send_sample(input logic signed [RAW_W-1:0] x,
                             input logic signed [RAW_W-1:0] y,
                             input bit typed, input reading_t want);
    sample_ch.valid <= 1'b1;
    sample_ch.raw_x <= x;
    sample_ch.raw_y <= y;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pending_readings.push_back(typed ? want : compute_reading(x, y));
    if (!quiet_tail && $urandom_range(3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // Register write, only once every outstanding result has come back.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    sample_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_OFFSET_X:    cal_off_x = data[RAW_W-1:0];
      REG_OFFSET_Y:    cal_off_y = data[RAW_W-1:0];
      REG_DECLINATION: cal_decl  = data[DECL_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver pacing: random stall bursts, none in the closing stretch.
  initial begin : drain_pacing
    int hold;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_tail) begin
        result_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        result_ch.ready <= 1'b0;
        hold = hold - 1;
      end else if ($urandom_range(5) == 0) begin
        result_ch.ready <= 1'b0;
        hold = $urandom_range(8, 1) - 1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest outstanding reading.
  always @(posedge clk) begin : check_results
    reading_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.hm = result_ch.heading_magnetic;
      got.ht = result_ch.heading_geo;
      got.fx = result_ch.field_x;
      got.fy = result_ch.field_y;
      if (pending_readings.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: hm=%0d ht=%0d fx=%0d fy=%0d",
                   got.hm, got.ht, got.fx, got.fy);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_readings.pop_front();
        if (got.hm !== want.hm || got.ht !== want.ht ||
            got.fx !== want.fx || got.fy !== want.fy) begin
          if (mismatch_count < 10)
            $display({"mismatch: expected hm=%0d ht=%0d fx=%0d fy=%0d, ",
                      "got hm=%0d ht=%0d fx=%0d fy=%0d"},
                     want.hm, want.ht, want.fx, want.fy, got.hm, got.ht, got.fx, got.fy);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog for a stuck handshake.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Main sequence: reset, directed table, then phases of random samples.
  initial begin : main_sequence
    dir_row_t table_rows[$];
    dir_row_t row;
    logic signed [RAW_W-1:0]  rx, ry, ox, oy;
    logic signed [DECL_W-1:0] dc;
    int p, n, pick;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.raw_x = '0;
    sample_ch.raw_y = '0;
    cal_off_x = '0;
    cal_off_y = '0;
    cal_decl = DECL_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero vector and the principal directions under the reset calibration.
    table_rows.push_back(row_zero(0, 0, 538));
    table_rows.push_back(row_sample(1000, 0));
    table_rows.push_back(row_sample(0, 1000));
    table_rows.push_back(row_sample(-1000, 0));
    table_rows.push_back(row_sample(0, -1000));
    table_rows.push_back(row_sample(1000, 1000));
    table_rows.push_back(row_sample(-1000, -1000));
    table_rows.push_back(row_sample(-1, 0));
    table_rows.push_back(row_sample(0, -1));
    table_rows.push_back(row_sample(1, 1));
    // Extremes of the raw fields.
    table_rows.push_back(row_sample(65535, 65535));
    table_rows.push_back(row_sample(-65536, -65536));
    table_rows.push_back(row_sample(65535, -65536));
    table_rows.push_back(row_sample(-65536, 65535));
    table_rows.push_back(row_sample(-65536, 0));
    // Extreme offsets push the corrected field to the ends of its range.
    table_rows.push_back(row_reg(REG_OFFSET_X, -65536));
    table_rows.push_back(row_reg(REG_OFFSET_Y, 65535));
    table_rows.push_back(row_sample(65535, -65536));
    table_rows.push_back(row_sample(-65536, -65536));
    table_rows.push_back(row_zero(-65536, 65535, 538));
    // Declination beyond half a turn is reduced modulo a full turn.
    table_rows.push_back(row_reg(REG_DECLINATION, 32767));
    table_rows.push_back(row_zero(-65536, 65535, 32767));
    table_rows.push_back(row_sample(0, 0));
    table_rows.push_back(row_reg(REG_DECLINATION, 'h18000));
    table_rows.push_back(row_zero(-65536, 65535, 3232));
    // A write to the unused index leaves everything alone.
    table_rows.push_back(row_reg(REG_UNUSED, 'h1ABCD));
    table_rows.push_back(row_zero(-65536, 65535, 3232));
    table_rows.push_back(row_reg(REG_DECLINATION, 18000));
    table_rows.push_back(row_zero(-65536, 65535, 18000));
    table_rows.push_back(row_reg(REG_DECLINATION, -18000));
    table_rows.push_back(row_zero(-65536, 65535, 18000));
    table_rows.push_back(row_sample(100, -100));

    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.is_reg) set_register(row.idx, row.data);
      else send_sample(row.x, row.y, row.typed, row.want);
    end

    for (p = 0; p < PHASES; p++) begin
      // Calibration of this phase: reset values, the extremes, then random settings.
      case (p)
        0: begin ox = '0; oy = '0; dc = DECL_RESET; end
        1: begin
          ox = RAW_W'(-65536);
          oy = RAW_W'(65535);
          dc = DECL_W'(32767);
        end
        2: begin
          ox = RAW_W'(65535);
          oy = RAW_W'(-65536);
          dc = DECL_W'(-32768);
        end
        3: begin
          ox = RAW_W'(int'($urandom_range(100000)) - 50000);
          oy = RAW_W'(int'($urandom_range(100000)) - 50000);
          dc = DECL_W'(18000);
        end
        4: begin
          ox = RAW_W'(int'($urandom_range(100000)) - 50000);
          oy = RAW_W'(int'($urandom_range(100000)) - 50000);
          dc = DECL_W'(-18000);
        end
        default: begin
          ox = RAW_W'($urandom());
          oy = RAW_W'($urandom());
          dc = (p % 2 == 0) ? DECL_W'(int'($urandom_range(36000)) - 18000)
                            : DECL_W'($urandom());
        end
      endcase
      set_register(REG_OFFSET_X, ox);
      set_register(REG_OFFSET_Y, oy);
      set_register(REG_DECLINATION, {1'($urandom()), dc});
      set_register(REG_UNUSED, CFG_W'($urandom()));
      if (p == PHASES - 1) quiet_tail = 1'b1;

      for (n = 0; n < SAMPLES_PER_PHASE; n++) begin
        pick = $urandom_range(9);
        case (pick)
          6, 7: begin
            rx = RAW_W'($urandom());
            ry = RAW_W'($urandom());
          end
          // Tiny corrected vectors around the origin, the zero vector among them.
          8: begin
            rx = RAW_W'(int'(cal_off_x) + int'($urandom_range(6)) - 3);
            ry = RAW_W'(int'(cal_off_y) + int'($urandom_range(6)) - 3);
          end
          // One corrected component exactly zero.
          9: begin
            rx = RAW_W'(int'($urandom_range(100000)) - 50000);
            ry = RAW_W'(int'($urandom_range(100000)) - 50000);
            if ($urandom_range(1) == 0) rx = cal_off_x;
            else ry = cal_off_y;
          end
          default: begin
            rx = RAW_W'(int'($urandom_range(100000)) - 50000);
            ry = RAW_W'(int'($urandom_range(100000)) - 50000);
          end
        endcase
        send_sample(rx, ry, 1'b0, '0);
      end
    end

    // Drain the pipeline and finish.
    sample_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
